FILE: hdl/record_table_with_auto_id_macros.svh
// Assertion macros shared by the record table checker.
`ifndef RECORD_TABLE_WITH_AUTO_ID_MACROS_SVH
`define RECORD_TABLE_WITH_AUTO_ID_MACROS_SVH

// Same-cycle implication.
`define RTAI_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record table assertion failed");

// Next-cycle implication.
`define RTAI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record table assertion failed");

`endif

FILE: hdl/rtai_pkg.sv
// Shared widths, codes and interface types of the record table.
package rtai_pkg;

    localparam int ID_W           = 27;
    localparam int SLOT_W         = 6;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_W        = ID_W + 1;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 64;
    localparam int TABLE_SIZE_DEF = 64;

    localparam logic [ID_W-1:0] ID_MAX = ID_W'(99999999);

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd3;

    // Sequencer to scan unit.
    typedef struct packed {
        logic start;       // clear accumulators
        logic step;        // an entry is on the read port
        logic match_en;    // compare against the key
        logic drop_match;  // matched entry is being freed
    } scan_ctrl_t;

    // Scan unit to sequencer.
    typedef struct packed {
        logic free_found;
        logic match_found;
        logic others_valid;
    } scan_flags_t;

endpackage

FILE: hdl/rtai_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtai_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/rtai_scan.sv
// Shared compare unit: first free slot, first key match and largest identifier.
module rtai_scan #(
    parameter int TABLE_SIZE = rtai_pkg::TABLE_SIZE_DEF,
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtai_pkg::scan_ctrl_t         ctrl,
    input  logic [AW-1:0]                idx,
    input  logic [rtai_pkg::ENTRY_W-1:0] entry,
    input  logic [rtai_pkg::ID_W-1:0]    key,
    output rtai_pkg::scan_flags_t        flags,
    output logic [AW-1:0]                free_pos,
    output logic [AW-1:0]                match_pos,
    output logic [rtai_pkg::ID_W-1:0]    best_id
);

    import rtai_pkg::*;

    scan_flags_t     flags_reg, flags_next;
    logic [AW-1:0]   free_pos_reg, free_pos_next;
    logic [AW-1:0]   match_pos_reg, match_pos_next;
    logic [ID_W-1:0] best_reg, best_next;
    logic            ent_valid;
    logic [ID_W-1:0] ent_id;
    logic            hit;
    logic            counts;

    assign ent_valid = entry[ENTRY_W-1];
    assign ent_id    = entry[ID_W-1:0];

    // only the lowest match is taken
    assign hit    = ctrl.match_en && ent_valid && (ent_id == key) && !flags_reg.match_found;
    // an entry that is about to be freed does not count toward max or occupancy
    assign counts = ent_valid && !(hit && ctrl.drop_match);

    always_comb
    begin
        flags_next     = flags_reg;
        free_pos_next  = free_pos_reg;
        match_pos_next = match_pos_reg;
        best_next      = best_reg;
        if (ctrl.start)
        begin
            flags_next = '0;
            best_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (!ent_valid && !flags_reg.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_pos_next         = idx;
            end
            if (hit)
            begin
                flags_next.match_found = 1'b1;
                match_pos_next         = idx;
            end
            if (counts)
            begin
                flags_next.others_valid = 1'b1;
                if (ent_id > best_reg)
                begin
                    best_next = ent_id;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_pos_reg  <= free_pos_next;
        match_pos_reg <= match_pos_next;
        best_reg      <= best_next;
    end

    assign flags     = flags_reg;
    assign free_pos  = free_pos_reg;
    assign match_pos = match_pos_reg;
    assign best_id   = best_reg;

endmodule

FILE: hdl/record_table_with_auto_id.sv
// Record table with automatic identifiers: sequencer, table RAM and output register.
//
// Each transaction (clear, insert, delete, lookup) returns one result. Insert, delete
// and lookup scan every entry of the table before the next acceptance; clear instead
// sweeps every entry to zero. The table RAM has one read port, so the scan for the free
// slot, the key match and the largest identifier visits one entry per cycle, followed
// by a done state that forms the result and writes back once the output register is
// free. After reset the RAM is swept clear with s_tready low. A finished result waits
// in the output register without blocking the next input transaction.
module record_table_with_auto_id #(
    parameter int TABLE_SIZE = rtai_pkg::TABLE_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rtai_pkg::S_TDATA_W-1:0] s_tdata,   // key_id[26:0]
    input  logic [rtai_pkg::MODE_W-1:0]    s_tuser,   // mode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rtai_pkg::M_TDATA_W-1:0] m_tdata,   // slot[5:0], id_out[32:6],
                                                      // is_empty[33], next_id[60:34]
    output logic [rtai_pkg::STATUS_W-1:0]  m_tuser    // status[1:0]
);

    import rtai_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_SIZE);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        rd_idx_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [ID_W-1:0]      key_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    logic                 accept;
    logic                 sweeping;
    logic                 out_free;
    logic                 finish;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;

    scan_ctrl_t           ctrl;
    scan_flags_t          flags;
    logic [AW-1:0]        free_pos;
    logic [AW-1:0]        match_pos;
    logic [ID_W-1:0]      best_id;

    logic [ID_W-1:0]      best_inc;
    logic [ID_W-1:0]      best_inc2;
    logic [ID_W-1:0]      next_keep;
    logic                 exhausted;

    logic [STATUS_W-1:0]  res_status;
    logic [SLOT_W-1:0]    res_slot;
    logic [ID_W-1:0]      res_id;
    logic                 res_empty;
    logic [ID_W-1:0]      res_next;
    logic                 wr_req;
    logic [AW-1:0]        wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sweeping = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    rtai_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_re    = (state_reg == ST_SCAN) && (cnt_reg != CNT_END);
    assign ram_we    = sweeping || (finish && wr_req);
    assign ram_waddr = sweeping ? cnt_reg[AW-1:0] : wr_addr;
    assign ram_wdata = sweeping ? '0 : wr_data;

    always_comb
    begin
        ctrl            = '0;
        ctrl.start      = accept;
        ctrl.step       = pend_reg;
        ctrl.match_en   = (mode_reg == MODE_DELETE) || (mode_reg == MODE_LOOKUP);
        ctrl.drop_match = (mode_reg == MODE_DELETE);
    end

    rtai_scan #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .idx       (rd_idx_reg),
        .entry     (ram_rdata),
        .key       (key_reg),
        .flags     (flags),
        .free_pos  (free_pos),
        .match_pos (match_pos),
        .best_id   (best_id)
    );

    // next_id with the table as the scan left it, and after a successful insert
    assign best_inc  = best_id + ID_W'(1);
    assign best_inc2 = best_id + ID_W'(2);
    assign exhausted = (best_id >= ID_MAX);
    assign next_keep = exhausted ? ID_MAX : best_inc;

    always_comb
    begin
        res_status = STATUS_OK;
        res_slot   = '0;
        res_id     = '0;
        res_empty  = !flags.others_valid;
        res_next   = next_keep;
        wr_req     = 1'b0;
        wr_addr    = free_pos;
        wr_data    = {1'b1, best_inc};
        case (mode_reg)
            MODE_CLEAR:
            begin
                res_empty = 1'b1;
                res_next  = ID_W'(1);
            end
            MODE_INSERT:
            begin
                if (!flags.free_found)
                begin
                    res_status = STATUS_FULL;
                end
                else if (exhausted)
                begin
                    res_status = STATUS_EXHAUSTED;
                end
                else
                begin
                    res_slot  = SLOT_W'(free_pos);
                    res_id    = best_inc;
                    res_empty = 1'b0;
                    res_next  = (best_id >= ID_MAX - ID_W'(1)) ? ID_MAX : best_inc2;
                    wr_req    = 1'b1;
                end
            end
            default:
            begin
                wr_addr = match_pos;
                wr_data = {1'b0, key_reg};
                if (!flags.match_found)
                begin
                    res_status = STATUS_NOT_FOUND;
                end
                else
                begin
                    res_slot = SLOT_W'(match_pos);
                    res_id   = key_reg;
                    wr_req   = (mode_reg == MODE_DELETE);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = (s_tuser == MODE_CLEAR) ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_END)
                begin
                    // last entry is folded in this cycle
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next  = cnt_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[AW-1:0];
        if (accept)
        begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[ID_W-1:0];
        end
        if (finish)
        begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= M_TDATA_W'({res_next, res_empty, res_id, res_slot});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hdl/rtai_checker.sv
// Port-level checker for the record table, bound to the top level.
`include "record_table_with_auto_id_macros.svh"

module rtai_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtai_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rtai_pkg::STATUS_W-1:0]  m_tuser
);

    import rtai_pkg::*;

    localparam int EMPTY_BIT = SLOT_W + ID_W;
    localparam int NEXT_LSB  = EMPTY_BIT + 1;

    `RTAI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one transaction in flight: ready drops right after an acceptance
    `RTAI_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // a failed operation reports no slot and no identifier
    `RTAI_ASSERT_NOW(a_fail_zero, clk, rst_n, m_tvalid && (m_tuser != STATUS_OK), m_tdata[EMPTY_BIT-1:0] == '0)

    // an empty table always hands out identifier one next
    `RTAI_ASSERT_NOW(a_empty_next, clk, rst_n, m_tvalid && m_tdata[EMPTY_BIT], m_tdata[NEXT_LSB+ID_W-1:NEXT_LSB] == ID_W'(1))

endmodule

bind record_table_with_auto_id rtai_checker u_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the record table with automatic identifiers.
`timescale 1ns / 100ps

import rtai_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     id_out;
    logic                is_empty;
    logic [ID_W-1:0]     next_id;
} table_result_t;

class record_table_tracker;
    localparam int ENTRIES = TABLE_SIZE_DEF;

    bit                live[ENTRIES];
    logic [ID_W-1:0]   ids[ENTRIES];
    table_result_t     pending[$];
    int                mismatches;

    function new();
        foreach (live[i])
        begin
            live[i] = 1'b0;
            ids[i]  = '0;
        end
        mismatches = 0;
    endfunction

    function logic [ID_W-1:0] largest_id();
        logic [ID_W-1:0] best;
        best = '0;
        foreach (live[i])
            if (live[i] && ids[i] > best)
                best = ids[i];
        return best;
    endfunction

    function int live_count();
        int n;
        n = 0;
        foreach (live[i])
            if (live[i])
                n++;
        return n;
    endfunction

    // Random identifier of a valid entry; 0 (never assigned) when the table is empty.
    function logic [ID_W-1:0] pick_live_id();
        int n;
        int k;
        n = live_count();
        if (n == 0)
            return '0;
        k = $urandom_range(0, n - 1);
        foreach (live[i])
        begin
            if (live[i])
            begin
                if (k == 0)
                    return ids[i];
                k--;
            end
        end
        return '0;
    endfunction

    // Apply one accepted transaction to the shadow table and queue its result.
    function void note_command(logic [MODE_W-1:0] mode, logic [ID_W-1:0] key);
        table_result_t   r;
        int              pos;
        logic [ID_W-1:0] top;
        r        = '0;
        r.status = STATUS_OK;
        pos      = -1;
        case (mode)
            MODE_CLEAR:
            begin
                foreach (live[i])
                    live[i] = 1'b0;
            end
            MODE_INSERT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!live[i] && pos < 0)
                        pos = i;
                end
                top = largest_id();
                if (pos < 0)
                    r.status = STATUS_FULL;
                else if (top >= ID_MAX)
                    r.status = STATUS_EXHAUSTED;
                else
                begin
                    live[pos] = 1'b1;
                    ids[pos]  = top + 1'b1;
                    r.slot    = SLOT_W'(pos);
                    r.id_out  = top + 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (live[i] && ids[i] == key && pos < 0)
                        pos = i;
                end
                if (pos < 0)
                    r.status = STATUS_NOT_FOUND;
                else
                begin
                    if (mode == MODE_DELETE)
                        live[pos] = 1'b0;
                    r.slot   = SLOT_W'(pos);
                    r.id_out = key;
                end
            end
        endcase
        top       = largest_id();
        r.next_id = (top >= ID_MAX) ? ID_MAX : top + 1'b1;
        r.is_empty = (live_count() == 0);
        pending.push_back(r);
    endfunction

    function void report(string what, table_result_t exp_r, table_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected st=%0d slot=%0d id=%0d empty=%0b next=%0d, got st=%0d slot=%0d id=%0d empty=%0b next=%0d",
                     $time, what, exp_r.status, exp_r.slot, exp_r.id_out, exp_r.is_empty,
                     exp_r.next_id, got.status, got.slot, got.id_out, got.is_empty,
                     got.next_id);
    endfunction

    function void check_result(table_result_t got);
        table_result_t exp_r;
        if (pending.size() == 0)
        begin
            report("unexpected result", '0, got);
            return;
        end
        exp_r = pending.pop_front();
        if (got.status !== exp_r.status || got.slot !== exp_r.slot
            || got.id_out !== exp_r.id_out || got.is_empty !== exp_r.is_empty
            || got.next_id !== exp_r.next_id)
            report("result mismatch", exp_r, got);
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 950;

    // fill phase, churn, drain, clear, noise
    localparam int PH_FILL  = 0;
    localparam int PH_CHURN = 1;
    localparam int PH_DRAIN = 2;
    localparam int PH_CLEAR = 3;
    localparam int PH_NOISE = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    record_table_tracker tracker;
    int                  cycle_count;
    int                  items_sent;
    bit                  quiet_phase;

    record_table_with_auto_id uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Mostly short gaps, a few long ones; none during quiet phases.
    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(30, 150);
    endfunction

    // Keys that normally miss: raw 27-bit noise, the ID limit, all ones, zero, largest ID + 1.
    function automatic logic [ID_W-1:0] pick_stray_key();
        case ($urandom_range(0, 4))
            0: return ID_MAX;
            1: return '1;
            2: return '0;
            3: return tracker.largest_id() + 1'b1;
            default: return ID_W'($urandom());
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(key);
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_command(mode, key);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic run_phase(input int kind, input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            case (kind)
                PH_FILL:
                    if (r < 85)
                        send_command(MODE_INSERT, ID_W'($urandom()));
                    else
                        send_command(MODE_LOOKUP, tracker.pick_live_id());
                PH_CHURN:
                    if (r < 35)
                        send_command(MODE_INSERT, ID_W'($urandom()));
                    else if (r < 65)
                        send_command(MODE_DELETE, tracker.pick_live_id());
                    else if (r < 85)
                        send_command(MODE_LOOKUP, tracker.pick_live_id());
                    else
                        send_command((r < 93) ? MODE_DELETE : MODE_LOOKUP, pick_stray_key());
                PH_DRAIN:
                    if (r < 75)
                        send_command(MODE_DELETE, tracker.pick_live_id());
                    else
                        send_command(MODE_LOOKUP, tracker.pick_live_id());
                PH_CLEAR:
                    send_command(MODE_CLEAR, ID_W'($urandom()));
                default:
                    send_command(MODE_W'($urandom_range(0, 3)), ID_W'($urandom()));
            endcase
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int hold;
            hold = pick_gap();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, quiet_phase ? 200 : 8)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        table_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status   = m_tuser;
            got.slot     = m_tdata[5:0];
            got.id_out   = m_tdata[32:6];
            got.is_empty = m_tdata[33];
            got.next_id  = m_tdata[60:34];
            tracker.check_result(got);
        end
    end

    initial
    begin
        int kind;
        int r;
        tracker     = new();
        cycle_count = 0;
        items_sent  = 0;
        quiet_phase = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_CLEAR;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-table misses, inserts, hits, misses on out-of-range keys,
        // deleting the largest ID, and insert after clear restarting at 1.
        send_command(MODE_CLEAR, '1);
        send_command(MODE_LOOKUP, '0);
        send_command(MODE_DELETE, '1);
        send_command(MODE_INSERT, '0);
        send_command(MODE_INSERT, '1);
        send_command(MODE_INSERT, 27'h5555555);
        send_command(MODE_INSERT, 27'h2AAAAAA);
        send_command(MODE_LOOKUP, 27'd3);
        send_command(MODE_LOOKUP, ID_MAX);
        send_command(MODE_LOOKUP, ID_MAX + 1'b1);
        send_command(MODE_DELETE, 27'd2);
        send_command(MODE_INSERT, '0);
        send_command(MODE_DELETE, 27'd5);
        send_command(MODE_DELETE, 27'd5);
        send_command(MODE_LOOKUP, '0);
        send_command(MODE_LOOKUP, 27'd1);
        send_command(MODE_LOOKUP, 27'h5555555);
        send_command(MODE_DELETE, 27'h2AAAAAA);
        send_command(MODE_INSERT, '0);
        send_command(MODE_CLEAR, '0);
        send_command(MODE_INSERT, '0);
        send_command(MODE_DELETE, 27'd1);

        // First random phase overfills the table so the full case is hit early.
        run_phase(PH_FILL, 80);
        while (items_sent < ITEM_TARGET)
        begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30)
                kind = PH_FILL;
            else if (r < 60)
                kind = PH_CHURN;
            else if (r < 80)
                kind = PH_DRAIN;
            else if (r < 85)
                kind = PH_CLEAR;
            else
                kind = PH_NOISE;
            run_phase(kind, (kind == PH_CLEAR) ? 1 : $urandom_range(10, 80));
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (TABLE_SIZE_DEF + 16) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
